/* src/kpeg_pkg.sv */
`timescale 1ns / 1ps
package kpeg_pkg;
    localparam int NUM_SAMPLES = 64;
    localparam int NUM_CLASSES = 4;
    localparam int SAMPLE_W    = $clog2(NUM_SAMPLES);
    localparam int CLASS_W     = 2;
    localparam int GRAM_W      = 16;
    localparam int ALPHA_W     = 16;
    localparam int MARGIN_W    = 38;
    localparam int PROD_W      = GRAM_W + ALPHA_W + 1;
    localparam int THRESH_W    = 33;
    localparam int CFG_W       = 16;

    typedef enum logic [1:0] {
        OP_CLEAR      = 2'd0,
        OP_LOAD_GRAM  = 2'd1,
        OP_LOAD_LABEL = 2'd2,
        OP_TRAIN      = 2'd3
    } t_op;

    typedef enum logic [0:0] {
        CFG_LAMBDA = 1'b0,
        CFG_LIMIT  = 1'b1
    } t_cfg_reg;
endpackage

/* src/kpeg_ram.sv */
`timescale 1ns / 1ps
module kpeg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* src/kernel_pegasos_trainer.sv */
`timescale 1ns / 1ps
// train step: 64 gram row reads, one own-row read, pipeline drain and a decide state,
//   then NUM_CLASSES result beats
// limit-reached step: fetch, wait and decide states, then NUM_CLASSES result beats
// clear and load beats are taken in idle and give no result; one item in flight at a time
// reset: synchronous active low; alpha row valid bits, step count and config registers
//   return to their reset values, gram and label memories keep their contents
module kernel_pegasos_trainer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [kpeg_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_operation,
    input  logic [5:0]                         i_row_index,
    input  logic [5:0]                         i_col_index,
    input  logic [1:0]                         i_class_select,
    input  logic signed [15:0]                 i_gram_value,
    input  logic                               i_label_positive,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [1:0]                         o_class_index,
    output logic signed [kpeg_pkg::MARGIN_W-1:0] o_margin,
    output logic                               o_updated,
    output logic [15:0]                        o_alpha_count,
    output logic                               o_limit_reached,
    output logic                               o_last_result
);
    import kpeg_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_ACC    = 6'b000010,
        ST_FETCH  = 6'b000100,
        ST_WAIT   = 6'b001000,
        ST_DECIDE = 6'b010000,
        ST_EMIT   = 6'b100000
    } t_state;

    t_state r_state;
    logic [15:0] r_lambda, r_limit_cfg, r_step;
    logic [NUM_SAMPLES-1:0] r_valid;
    logic [SAMPLE_W-1:0] r_sample, r_j;
    logic r_limit;
    logic [THRESH_W-1:0] r_thresh;
    logic r_p1_v, r_p2_v, r_rd_vld;
    logic signed [PROD_W-1:0] r_prod [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_plab, r_own_lab;
    logic signed [MARGIN_W-1:0] r_acc [NUM_CLASSES];
    logic [ALPHA_W-1:0] r_own_alpha [NUM_CLASSES];
    logic [ALPHA_W-1:0] r_res_alpha [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] r_res_upd;
    logic [CLASS_W-1:0] r_k;

    logic in_acc, out_acc;
    logic [SAMPLE_W-1:0] rd_addr;
    logic signed [GRAM_W-1:0] gram_q;
    logic [ALPHA_W-1:0] alpha_q [NUM_CLASSES];
    logic [ALPHA_W-1:0] alpha_new [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] lab_q, upd;
    logic alpha_we;

    assign in_acc      = i_valid && o_ready;
    assign out_acc     = o_valid && i_ready;
    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // read address: walk j during accumulation, own sample row afterwards
    assign rd_addr = (r_state == ST_ACC) ? r_j : r_sample;

    kpeg_ram #(.WIDTH(GRAM_W), .DEPTH(NUM_SAMPLES * NUM_SAMPLES)) u_gram (
        .i_clk   (i_clk),
        .i_we    (in_acc && (t_op'(i_operation) == OP_LOAD_GRAM)),
        .i_waddr ({i_row_index, i_col_index}),
        .i_wdata (i_gram_value),
        .i_raddr ({r_sample, r_j}),
        .o_rdata (gram_q)
    );

    // per-class label and alpha memories
    for (genvar n = 0; n < NUM_CLASSES; n++) begin : g_class
        kpeg_ram #(.WIDTH(1), .DEPTH(NUM_SAMPLES)) u_label (
            .i_clk   (i_clk),
            .i_we    (in_acc && (t_op'(i_operation) == OP_LOAD_LABEL) &&
                      (i_class_select == CLASS_W'(n))),
            .i_waddr (i_row_index),
            .i_wdata (i_label_positive),
            .i_raddr (rd_addr),
            .o_rdata (lab_q[n])
        );
        kpeg_ram #(.WIDTH(ALPHA_W), .DEPTH(NUM_SAMPLES)) u_alpha (
            .i_clk   (i_clk),
            .i_we    (alpha_we),
            .i_waddr (r_sample),
            .i_wdata (alpha_new[n]),
            .i_raddr (rd_addr),
            .o_rdata (alpha_q[n])
        );
    end

    // decide: signed margin against lambda * t, saturating increment
    always_comb begin
        logic signed [MARGIN_W:0] s;
        for (int n = 0; n < NUM_CLASSES; n++) begin
            s = r_own_lab[n] ? (MARGIN_W+1)'(r_acc[n]) : -(MARGIN_W+1)'(r_acc[n]);
            upd[n] = !r_limit && (s < $signed({(MARGIN_W+1-THRESH_W)'(0), r_thresh}));
            alpha_new[n] = (upd[n] && (r_own_alpha[n] != '1)) ?
                           r_own_alpha[n] + ALPHA_W'(1) : r_own_alpha[n];
        end
    end
    assign alpha_we = (r_state == ST_DECIDE) && !r_limit;

    // sequencer and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_lambda    <= 16'd4096;
            r_limit_cfg <= 16'd65535;
            r_step      <= '0;
            r_valid     <= '0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_j         <= '0;
            r_k         <= '0;
        end else begin
            if (i_cfg_valid) begin
                if (t_cfg_reg'(i_cfg_index) == CFG_LAMBDA) r_lambda <= i_cfg_data;
                else r_limit_cfg <= i_cfg_data;
            end
            r_p1_v <= (r_state == ST_ACC);
            r_p2_v <= r_p1_v;
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (t_op'(i_operation))
                            OP_CLEAR: begin
                                r_valid <= '0;
                                r_step  <= '0;
                            end
                            OP_TRAIN: begin
                                r_j     <= '0;
                                r_state <= (r_step >= r_limit_cfg) ? ST_FETCH : ST_ACC;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ACC: begin
                    r_j <= r_j + SAMPLE_W'(1);
                    if (r_j == SAMPLE_W'(NUM_SAMPLES - 1)) r_state <= ST_FETCH;
                end
                ST_FETCH:  r_state <= ST_WAIT;
                ST_WAIT:   r_state <= ST_DECIDE;
                ST_DECIDE: begin
                    if (!r_limit) begin
                        r_valid[r_sample] <= 1'b1;
                        r_step <= r_step + 16'd1;
                    end
                    r_k     <= '0;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_acc) begin
                        r_k <= r_k + CLASS_W'(1);
                        if (r_k == CLASS_W'(NUM_CLASSES - 1)) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath: step setup, multiply stage, accumulate stage, own-row capture, result capture
    always_ff @(posedge i_clk) begin
        if (in_acc && (t_op'(i_operation) == OP_TRAIN)) begin
            r_sample <= i_row_index;
            r_limit  <= (r_step >= r_limit_cfg);
            r_thresh <= THRESH_W'(r_lambda * ({1'b0, r_step} + 17'd1));
            for (int n = 0; n < NUM_CLASSES; n++) r_acc[n] <= '0;
        end
        r_rd_vld <= r_valid[rd_addr];
        for (int n = 0; n < NUM_CLASSES; n++) begin
            r_prod[n] <= PROD_W'(gram_q * $signed({1'b0,
                         (r_rd_vld ? alpha_q[n] : ALPHA_W'(0))}));
            r_plab[n] <= lab_q[n];
            if (r_p2_v) begin
                r_acc[n] <= r_plab[n] ? r_acc[n] + MARGIN_W'(r_prod[n])
                                      : r_acc[n] - MARGIN_W'(r_prod[n]);
            end
        end
        if (r_state == ST_WAIT) begin
            for (int n = 0; n < NUM_CLASSES; n++)
                r_own_alpha[n] <= r_rd_vld ? alpha_q[n] : ALPHA_W'(0);
            r_own_lab <= lab_q;
        end
        if (r_state == ST_DECIDE) begin
            r_res_upd <= upd;
            for (int n = 0; n < NUM_CLASSES; n++) r_res_alpha[n] <= alpha_new[n];
        end
    end

    // result beats, one per class
    assign o_valid         = (r_state == ST_EMIT);
    assign o_class_index   = r_k;
    assign o_margin        = r_acc[r_k];
    assign o_updated       = r_res_upd[r_k];
    assign o_alpha_count   = r_res_alpha[r_k];
    assign o_limit_reached = r_limit;
    assign o_last_result   = (r_k == CLASS_W'(NUM_CLASSES - 1));
endmodule

/* src/kpeg_checker.sv */
`timescale 1ns / 1ps
module kpeg_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_ready,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic [1:0]                         o_class_index,
    input logic signed [kpeg_pkg::MARGIN_W-1:0] o_margin,
    input logic                               o_updated,
    input logic                               o_limit_reached,
    input logic                               o_last_result
);
    import kpeg_pkg::*;

    // a pending result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_class_index))
        else $error("result beat dropped or changed while stalled");

    // no input beat taken while results are pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input accepted while results pending");

    // last flag marks the top class
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_result == (o_class_index == 2'(NUM_CLASSES - 1))))
        else $error("last flag on wrong class");

    // an ignored step changes nothing and shows a zero margin
    a_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_limit_reached |-> !o_updated && (o_margin == '0))
        else $error("limit step reported an update");
endmodule

bind kernel_pegasos_trainer kpeg_checker u_kpeg_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_class_index   (o_class_index),
    .o_margin        (o_margin),
    .o_updated       (o_updated),
    .o_limit_reached (o_limit_reached),
    .o_last_result   (o_last_result)
);

/* verif/kernel_pegasos_trainer_tb.sv */
`timescale 1ns / 1ps
module kernel_pegasos_trainer_tb;
    import kpeg_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    // samples that train steps pick from; their gram rows and labels are loaded first
    localparam logic [5:0] ROW_A = 6'd0;
    localparam logic [5:0] ROW_B = 6'd63;

    typedef struct packed {
        logic [1:0]  class_index;
        logic [37:0] margin;
        logic        updated;
        logic [15:0] alpha_count;
        logic        limit_reached;
        logic        last_result;
    } t_class_result;

    // scoreboard: trainer state mirror plus queue of expected class results
    class trainer_scoreboard;
        logic [15:0] gram_mem [NUM_SAMPLES*NUM_SAMPLES];
        logic        label_mem [NUM_SAMPLES*NUM_CLASSES];
        logic [15:0] alpha_mem [NUM_SAMPLES*NUM_CLASSES];
        logic [15:0] steps;
        logic [15:0] lambda_q12;
        logic [15:0] step_limit;
        t_class_result pending [$];
        int errors;

        function void reset_state();
            foreach (gram_mem[k]) gram_mem[k] = '0;
            foreach (label_mem[k]) label_mem[k] = 1'b0;
            foreach (alpha_mem[k]) alpha_mem[k] = '0;
            steps = '0;
            lambda_q12 = 16'd4096;
            step_limit = 16'hffff;
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [15:0] val);
            if (idx == CFG_LAMBDA) lambda_q12 = val;
            else step_limit = val;
        endfunction

        // update model state for one input beat and queue its results
        function void note_input(t_op op, logic [5:0] row, logic [5:0] col,
                                 logic [1:0] cls, logic [15:0] gval, logic lpos);
            logic limit_hit;
            longint thresh, acc, lbl;
            t_class_result r;
            int ai;
            case (op)
                OP_CLEAR: begin
                    foreach (alpha_mem[k]) alpha_mem[k] = '0;
                    steps = '0;
                end
                OP_LOAD_GRAM: gram_mem[row*NUM_SAMPLES + col] = gval;
                OP_LOAD_LABEL: label_mem[row*NUM_CLASSES + cls] = lpos;
                OP_TRAIN: begin
                    limit_hit = steps >= step_limit;
                    thresh = longint'(lambda_q12) * (longint'(steps) + 1);
                    for (int n = 0; n < NUM_CLASSES; n++) begin
                        ai = row*NUM_CLASSES + n;
                        acc = 0;
                        r = '0;
                        if (!limit_hit) begin
                            for (int j = 0; j < NUM_SAMPLES; j++) begin
                                lbl = label_mem[j*NUM_CLASSES + n] ? 1 : -1;
                                acc += longint'($signed(gram_mem[row*NUM_SAMPLES + j]))
                                       * longint'(alpha_mem[j*NUM_CLASSES + n]) * lbl;
                            end
                            lbl = label_mem[ai] ? 1 : -1;
                            if (lbl * acc < thresh) begin
                                r.updated = 1'b1;
                                if (alpha_mem[ai] != 16'hffff) alpha_mem[ai]++;
                            end
                        end
                        r.class_index = n[1:0];
                        r.margin = acc[37:0];
                        r.alpha_count = alpha_mem[ai];
                        r.limit_reached = limit_hit;
                        r.last_result = (n == NUM_CLASSES-1);
                        pending = {pending, r};
                    end
                    if (!limit_hit) steps++;
                end
            endcase
        endfunction

        function void check_result(t_class_result got);
            t_class_result want;
            if (pending.size() == 0) begin
                $error("unexpected result beat class %0d", got.class_index);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.class_index !== want.class_index) begin
                $error("class_index exp %0d got %0d", want.class_index, got.class_index);
                errors++;
            end
            if (got.margin !== want.margin) begin
                $error("margin exp %0d got %0d", $signed(want.margin), $signed(got.margin));
                errors++;
            end
            if (got.updated !== want.updated) begin
                $error("updated exp %0b got %0b", want.updated, got.updated);
                errors++;
            end
            if (got.alpha_count !== want.alpha_count) begin
                $error("alpha_count exp %0d got %0d", want.alpha_count, got.alpha_count);
                errors++;
            end
            if (got.limit_reached !== want.limit_reached) begin
                $error("limit_reached exp %0b got %0b", want.limit_reached,
                       got.limit_reached);
                errors++;
            end
            if (got.last_result !== want.last_result) begin
                $error("last_result exp %0b got %0b", want.last_result, got.last_result);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = '0;
    logic [5:0]  i_row_index = '0;
    logic [5:0]  i_col_index = '0;
    logic [1:0]  i_class_select = '0;
    logic signed [15:0] i_gram_value = '0;
    logic        i_label_positive = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_class_index;
    logic signed [37:0] o_margin;
    logic        o_updated;
    logic [15:0] o_alpha_count;
    logic        o_limit_reached;
    logic        o_last_result;

    trainer_scoreboard sb;
    int  cycles = 0;
    bit  sink_enable = 1'b0;
    bit  sink_steady = 1'b0;

    kernel_pegasos_trainer dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("kernel_pegasos_trainer regression: fail");
            $finish;
        end
    end

    // result beat checking
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_result({o_class_index, o_margin, o_updated, o_alpha_count,
                             o_limit_reached, o_last_result});
    end

    // result ready with random stalls, none while sink_steady is set
    initial begin
        int gap;
        @(negedge i_clk);
        forever begin
            if (!sink_enable) begin
                i_ready <= 1'b0;
                @(negedge i_clk);
            end else begin
                gap = sink_steady ? 0 : $urandom_range(0, 7);
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
                i_ready <= 1'b1;
                @(posedge i_clk);
                while (!o_valid) @(posedge i_clk);
                @(negedge i_clk);
            end
        end
    end

    // valid stays high into a back-to-back beat; drain() drops it after the last one
    task automatic send_item(t_op op, logic [5:0] row, logic [5:0] col,
                             logic [1:0] cls, logic [15:0] gval, logic lpos,
                             bit no_gap = 0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_row_index <= row;
        i_col_index <= col;
        i_class_select <= cls;
        i_gram_value <= gval;
        i_label_positive <= lpos;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_input(op, row, col, cls, gval, lpos);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    // only while the block is idle
    task automatic write_reg(t_cfg_reg idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // mode 0: random kernels, otherwise extreme kernels
    task automatic load_gram_row(logic [5:0] row, int mode);
        logic [15:0] v;
        for (int c = 0; c < NUM_SAMPLES; c++) begin
            if (mode == 0) v = 16'($urandom);
            else v = (row == 6'(c)) ? 16'h7fff : 16'h8000;
            send_item(OP_LOAD_GRAM, row, 6'(c), 2'($urandom), v, 1'($urandom), 1);
        end
    endtask

    task automatic load_labels_row(logic [5:0] row);
        for (int n = 0; n < NUM_CLASSES; n++)
            send_item(OP_LOAD_LABEL, row, 6'($urandom), 2'(n), 16'($urandom),
                      1'($urandom), 1);
    endtask

    function automatic logic [5:0] train_row();
        return ($urandom_range(0, 1) == 0) ? ROW_A : ROW_B;
    endfunction

    task automatic train_burst(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(OP_CLEAR, 6'($urandom), 6'($urandom), 2'($urandom),
                          16'($urandom), 1'($urandom));
            else if ($urandom_range(0, 9) == 0)
                send_item(OP_LOAD_GRAM, 6'($urandom), 6'($urandom), 2'($urandom),
                          16'($urandom), 1'($urandom));
            else if ($urandom_range(0, 9) == 0)
                send_item(OP_LOAD_LABEL, 6'($urandom), 6'($urandom), 2'($urandom),
                          16'($urandom), 1'($urandom));
            else
                send_item(OP_TRAIN, train_row(), 6'($urandom), 2'($urandom),
                          16'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        sink_enable = 1'b1;

        // every entry a train step depends on is written before the first step
        sink_steady = 1'b1;
        load_gram_row(ROW_A, 1);
        load_gram_row(ROW_B, 0);
        load_labels_row(ROW_A);
        load_labels_row(ROW_B);
        sink_steady = 1'b0;

        // directed: extreme kernels, first steps, limit of one
        send_item(OP_TRAIN, ROW_A, 6'd0, 2'd0, 16'd0, 1'b0);
        send_item(OP_TRAIN, ROW_B, 6'd63, 2'd3, 16'hffff, 1'b1);
        send_item(OP_TRAIN, ROW_A, 6'd0, 2'd0, 16'd0, 1'b0);
        send_item(OP_LOAD_GRAM, 6'd0, 6'd63, 2'd3, 16'h7fff, 1'b1);
        send_item(OP_LOAD_LABEL, 6'd63, 6'd0, 2'd0, 16'h8000, 1'b1);
        send_item(OP_TRAIN, ROW_B, 6'd0, 2'd0, 16'd0, 1'b0);
        send_item(OP_TRAIN, ROW_A, 6'd0, 2'd0, 16'd0, 1'b0);
        drain();
        write_reg(CFG_LIMIT, 16'd1);
        write_reg(CFG_LAMBDA, 16'd0);
        send_item(OP_CLEAR, 6'd0, 6'd0, 2'd0, 16'd0, 1'b0);
        send_item(OP_TRAIN, ROW_A, 6'd0, 2'd0, 16'd0, 1'b0);
        send_item(OP_TRAIN, ROW_A, 6'd0, 2'd0, 16'd0, 1'b0);
        send_item(OP_TRAIN, ROW_B, 6'd0, 2'd0, 16'd0, 1'b0);
        drain();

        // random: lambda extremes and mid values, several limits
        write_reg(CFG_LAMBDA, 16'hffff);
        write_reg(CFG_LIMIT, 16'hffff);
        send_item(OP_CLEAR, 6'($urandom), 6'($urandom), 2'($urandom), 16'($urandom),
                  1'($urandom));
        train_burst(40);
        drain();
        write_reg(CFG_LAMBDA, 16'd4096);
        write_reg(CFG_LIMIT, 16'd20);
        send_item(OP_CLEAR, 6'($urandom), 6'($urandom), 2'($urandom), 16'($urandom),
                  1'($urandom));
        train_burst(40);
        drain();
        write_reg(CFG_LAMBDA, 16'($urandom_range(0, 65535)));
        write_reg(CFG_LIMIT, 16'd65535);
        train_burst(50);
        drain();
        write_reg(CFG_LAMBDA, 16'd0);
        write_reg(CFG_LIMIT, 16'($urandom_range(1, 200)));
        sink_steady = 1'b1;
        train_burst(40);
        sink_steady = 1'b0;

        drain();
        if (sb.errors == 0)
            $display("kernel_pegasos_trainer regression: pass");
        else
            $display("kernel_pegasos_trainer regression: fail");
        $finish;
    end
endmodule

/* sim.f */
src/kpeg_pkg.sv
src/kpeg_ram.sv
src/kernel_pegasos_trainer.sv
src/kpeg_checker.sv
verif/kernel_pegasos_trainer_tb.sv
